// ----- hw/rtl/esiq_pkg.sv -----
package esiq_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_HOLD_TICKS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WAKE_IGNORE_TIME     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_STEP            = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_HOLD_TIME      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS_HOLD_TIME = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS_AMOUNT    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DELTA_MULTIPLIER     = 3'd6;

  localparam int DELTA_W = 20;
  localparam int ACC_W   = 24;
  localparam int HELD_W  = 17;
  localparam int STEP_W  = 8;
  localparam int MULT_W  = 4;

  localparam logic [HELD_W-1:0] HELD_MAX = 17'h1FFFF;

  localparam int DELTA_MAX = 524287;
  localparam int DELTA_MIN = -524288;
  localparam int ACC_MAX   = 8388607;
  localparam int ACC_MIN   = -8388608;

  localparam logic [15:0]       RST_SWITCH_HOLD_TICKS    = 16'd100;
  localparam logic [15:0]       RST_WAKE_IGNORE_TIME     = 16'd500;
  localparam logic [STEP_W-1:0] RST_TICK_STEP            = 8'd1;
  localparam logic [15:0]       RST_SLEEP_HOLD_TIME      = 16'd3000;
  localparam logic [15:0]       RST_BRIGHTNESS_HOLD_TIME = 16'd500;
  localparam logic [15:0]       RST_BRIGHTNESS_AMOUNT    = 16'd10;
  localparam logic [MULT_W-1:0] RST_DELTA_MULTIPLIER     = 4'd1;

endpackage

// ----- hw/rtl/encoder_switch_input_qualifier.sv -----
// Channel | Direction | Handshake                  | Contents
// tick    | in        | tick_valid, tick_stall     | switch, edge flags, encoder position, wake
// result  | out       | result_valid, result_stall | jump, deltas, sleep, activity
// cfg     | in        | cfg_valid, cfg_ready       | register index and write data
//
// Each tick is captured in an input register and qualified from there into the result register,
// and one tick is taken every clock unless the result register is full and stalled. The single
// pass of qualify logic, including the one multiply, sets that
// rate. Reset is synchronous and clears the control state and loads the register defaults.
// The input stalls only while a captured tick cannot move into a result register that is
// full and stalled.
module encoder_switch_input_qualifier #(
  parameter int POSITION_BITS = 16,
  parameter int TIMER_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick_valid,
  output logic                                tick_stall,
  input  logic                                switch_pressed,
  input  logic                                switch_edge_seen,
  input  logic                                encoder_edge_seen,
  input  logic signed [POSITION_BITS-1:0]     encoder_position,
  input  logic                                wake_clear,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                jump_color,
  output logic signed [esiq_pkg::DELTA_W-1:0] color_delta,
  output logic signed [esiq_pkg::DELTA_W-1:0] brightness_delta,
  output logic                                sleep_request,
  output logic                                activity,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [esiq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [esiq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PROD_W = POSITION_BITS + esiq_pkg::MULT_W + 1;
  localparam int WIDE_W = (PROD_W + 1 > esiq_pkg::ACC_W + 2) ? PROD_W + 1 : esiq_pkg::ACC_W + 2;
  localparam int HW     = esiq_pkg::HELD_W;
  localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

  logic [15:0]                  switch_hold_ticks;
  logic [15:0]                  wake_ignore_time;
  logic [esiq_pkg::STEP_W-1:0]  tick_step;
  logic [15:0]                  sleep_hold_time;
  logic [15:0]                  brightness_hold_time;
  logic [15:0]                  brightness_amount;
  logic [esiq_pkg::MULT_W-1:0]  delta_multiplier;

  logic                         in_full;
  logic                         in_pressed;
  logic                         in_sw_edge;
  logic                         in_enc_edge;
  logic [POSITION_BITS-1:0]     in_position;
  logic                         in_wake;

  logic [TIMER_BITS-1:0]        poll_hold_left, poll_hold_left_next;
  logic [TIMER_BITS-1:0]        edge_hold_left, edge_hold_left_next;
  logic [TIMER_BITS-1:0]        ignore_left, ignore_left_next;
  logic                         poll_active, poll_active_next;
  logic                         press_latched, press_latched_next;
  logic [HW-1:0]                held_time, held_time_next;
  logic signed [esiq_pkg::ACC_W-1:0] brightness_accum, brightness_accum_next;
  logic                         sleep_cancelled, sleep_cancelled_next;
  logic [POSITION_BITS-1:0]     last_position;

  logic                         advance;
  logic                         tick_accept;
  logic                         jump_next;
  logic signed [esiq_pkg::DELTA_W-1:0] color_next, bright_next;
  logic                         sleep_next;
  logic                         activity_next;

  logic [esiq_pkg::STEP_W-1:0]  step8;
  logic [TIMER_BITS-1:0]        step_t;
  logic [TIMER_BITS-1:0]        reload;
  logic [TIMER_BITS-1:0]        ignore_load;
  logic [TIMER_BITS-1:0]        ph0, eh0, ign0, ph1, eh1;
  logic [HW-1:0]                held0, held_sat;
  logic [HW:0]                  held_sum;
  logic signed [esiq_pkg::ACC_W-1:0] acc0;
  logic                         canc0;
  logic                         edge_active, received;
  logic [POSITION_BITS-1:0]     pos_diff;
  logic signed [PROD_W-1:0]     product;
  logic signed [WIDE_W-1:0]     delta_w, acc_sum, acc_sat, acc_abs;

  assign cfg_ready   = 1'b1;
  assign advance     = in_full && (!result_valid || !result_stall);
  assign tick_stall  = in_full && !advance;
  assign tick_accept = tick_valid && !tick_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_hold_ticks    <= esiq_pkg::RST_SWITCH_HOLD_TICKS;
      wake_ignore_time     <= esiq_pkg::RST_WAKE_IGNORE_TIME;
      tick_step            <= esiq_pkg::RST_TICK_STEP;
      sleep_hold_time      <= esiq_pkg::RST_SLEEP_HOLD_TIME;
      brightness_hold_time <= esiq_pkg::RST_BRIGHTNESS_HOLD_TIME;
      brightness_amount    <= esiq_pkg::RST_BRIGHTNESS_AMOUNT;
      delta_multiplier     <= esiq_pkg::RST_DELTA_MULTIPLIER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        esiq_pkg::REG_SWITCH_HOLD_TICKS:    switch_hold_ticks    <= cfg_data;
        esiq_pkg::REG_WAKE_IGNORE_TIME:     wake_ignore_time     <= cfg_data;
        esiq_pkg::REG_TICK_STEP:            tick_step            <= cfg_data[esiq_pkg::STEP_W-1:0];
        esiq_pkg::REG_SLEEP_HOLD_TIME:      sleep_hold_time      <= cfg_data;
        esiq_pkg::REG_BRIGHTNESS_HOLD_TIME: brightness_hold_time <= cfg_data;
        esiq_pkg::REG_BRIGHTNESS_AMOUNT:    brightness_amount    <= cfg_data;
        esiq_pkg::REG_DELTA_MULTIPLIER:     delta_multiplier     <= cfg_data[esiq_pkg::MULT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= tick_accept || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      in_pressed  <= switch_pressed;
      in_sw_edge  <= switch_edge_seen;
      in_enc_edge <= encoder_edge_seen;
      in_position <= $unsigned(encoder_position);
      in_wake     <= wake_clear;
    end
  end

  always_comb begin
    step8       = (tick_step == '0) ? esiq_pkg::STEP_W'(1) : tick_step;
    step_t      = TIMER_BITS'(step8);
    reload      = (33'(switch_hold_ticks) > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                                       : TIMER_BITS'(switch_hold_ticks);
    ignore_load = (33'(wake_ignore_time) > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                                      : TIMER_BITS'(wake_ignore_time);

    ph0   = in_wake ? '0 : poll_hold_left;
    eh0   = in_wake ? '0 : edge_hold_left;
    ign0  = in_wake ? ignore_load : ignore_left;
    held0 = in_wake ? '0 : held_time;
    acc0  = in_wake ? '0 : brightness_accum;
    canc0 = in_wake ? 1'b0 : sleep_cancelled;

    activity_next = in_sw_edge || in_enc_edge;

    eh1         = (in_sw_edge && ign0 == '0) ? reload : eh0;
    edge_active = eh1 != '0;
    ph1         = (in_pressed && ign0 == '0) ? reload : ph0;
    poll_active_next = ph1 != '0;
    if (poll_active_next != poll_active) begin
      activity_next = 1'b1;
    end

    received           = edge_active && poll_active_next;
    jump_next          = 1'b0;
    press_latched_next = press_latched;
    if (!press_latched) begin
      if (received) begin
        jump_next          = 1'b1;
        press_latched_next = 1'b1;
      end
    end else if (!edge_active && !poll_active_next) begin
      press_latched_next = 1'b0;
    end

    poll_hold_left_next = (ph1 > step_t) ? ph1 - step_t : '0;
    edge_hold_left_next = (eh1 > step_t) ? eh1 - step_t : '0;
    ignore_left_next    = (ign0 > step_t) ? ign0 - step_t : '0;

    held_sum             = {1'b0, held0} + (HW + 1)'(step8);
    held_sat             = (held_sum > {1'b0, esiq_pkg::HELD_MAX}) ? esiq_pkg::HELD_MAX
                                                                   : held_sum[HW-1:0];
    sleep_next           = 1'b0;
    held_time_next       = held_sat;
    brightness_accum_next = acc0;
    sleep_cancelled_next = canc0;
    if (poll_active_next) begin
      if (sleep_hold_time != '0) begin
        if (held_sat >= HW'(sleep_hold_time)) begin
          if (canc0) begin
            held_time_next = HW'(sleep_hold_time);
          end else begin
            sleep_next = 1'b1;
          end
        end
      end else if (held_sat > HW'(brightness_hold_time)) begin
        held_time_next = HW'(brightness_hold_time);
      end
    end else begin
      held_time_next        = '0;
      brightness_accum_next = '0;
      sleep_cancelled_next  = 1'b0;
    end

    pos_diff = last_position - in_position;
    product  = PROD_W'($signed(pos_diff)) * PROD_W'($signed({1'b0, delta_multiplier}));
    delta_w  = WIDE_W'(product);
    acc_sum  = WIDE_W'(acc0) + delta_w;
    if (acc_sum > WIDE_W'(esiq_pkg::ACC_MAX)) begin
      acc_sat = WIDE_W'(esiq_pkg::ACC_MAX);
    end else if (acc_sum < WIDE_W'(esiq_pkg::ACC_MIN)) begin
      acc_sat = WIDE_W'(esiq_pkg::ACC_MIN);
    end else begin
      acc_sat = acc_sum;
    end
    acc_abs = (acc_sat < 0) ? -acc_sat : acc_sat;

    color_next  = '0;
    bright_next = '0;
    if (delta_w != '0) begin
      if (delta_w > WIDE_W'(esiq_pkg::DELTA_MAX)) begin
        delta_w = WIDE_W'(esiq_pkg::DELTA_MAX);
      end else if (delta_w < WIDE_W'(esiq_pkg::DELTA_MIN)) begin
        delta_w = WIDE_W'(esiq_pkg::DELTA_MIN);
      end
      if (brightness_hold_time != '0 && held_time_next >= HW'(brightness_hold_time)) begin
        bright_next           = delta_w[esiq_pkg::DELTA_W-1:0];
        brightness_accum_next = acc_sat[esiq_pkg::ACC_W-1:0];
        if (acc_abs >= $signed({{(WIDE_W-16){1'b0}}, brightness_amount})) begin
          sleep_cancelled_next = 1'b1;
        end
      end else begin
        color_next = delta_w[esiq_pkg::DELTA_W-1:0];
      end
      activity_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_hold_left   <= '0;
      edge_hold_left   <= '0;
      ignore_left      <= '0;
      poll_active      <= 1'b0;
      press_latched    <= 1'b0;
      held_time        <= '0;
      brightness_accum <= '0;
      sleep_cancelled  <= 1'b0;
      last_position    <= '0;
    end else if (advance) begin
      poll_hold_left   <= poll_hold_left_next;
      edge_hold_left   <= edge_hold_left_next;
      ignore_left      <= ignore_left_next;
      poll_active      <= poll_active_next;
      press_latched    <= press_latched_next;
      held_time        <= held_time_next;
      brightness_accum <= brightness_accum_next;
      sleep_cancelled  <= sleep_cancelled_next;
      last_position    <= in_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      jump_color       <= jump_next;
      color_delta      <= color_next;
      brightness_delta <= bright_next;
      sleep_request    <= sleep_next;
      activity         <= activity_next;
    end
  end

`ifndef ASSERT_OFF
  a_latch_rise_jumps: assert property (@(posedge clk) disable iff (rst)
    $rose(press_latched) |-> result_valid && jump_color)
    else $error("press latch set without a jump result");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> result_valid && result_stall)
    else $error("input stalled while the result register could take a transfer");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(held_time) && $stable(press_latched) && $stable(last_position))
    else $error("qualifier state changed without a tick");
`endif

endmodule

// ----- sim/esiq_check_pkg.sv -----
`timescale 1ns / 1ps

package esiq_check_pkg;
  import esiq_pkg::*;

  typedef struct {
    bit                 pressed;
    bit                 sw_edge;
    bit                 enc_edge;
    logic signed [15:0] position;
    bit                 wake;
  } tick_t;

  typedef struct {
    logic               jump;
    logic [DELTA_W-1:0] color;
    logic [DELTA_W-1:0] bright;
    logic               sleep;
    logic               act;
  } outcome_t;

  typedef struct {
    int hold;
    int ignore;
    int step;
    int sleep;
    int bright;
    int amount;
    int mult;
  } reg_set_t;

  class qualifier_scoreboard;
    int hold_ticks;
    int ignore_time;
    int tick_step;
    int sleep_time;
    int bright_time;
    int cancel_amount;
    int multiplier;

    int          poll_left;
    int          edge_left;
    int          ignore_left;
    int          held;
    int          accum;
    bit          poll_on;
    bit          latched;
    bit          cancelled;
    logic [15:0] last_pos;

    outcome_t outcomes[$];
    int       errors;

    function new();
      hold_ticks    = RST_SWITCH_HOLD_TICKS;
      ignore_time   = RST_WAKE_IGNORE_TIME;
      tick_step     = RST_TICK_STEP;
      sleep_time    = RST_SLEEP_HOLD_TIME;
      bright_time   = RST_BRIGHTNESS_HOLD_TIME;
      cancel_amount = RST_BRIGHTNESS_AMOUNT;
      multiplier    = RST_DELTA_MULTIPLIER;
      last_pos      = '0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SWITCH_HOLD_TICKS:    hold_ticks = data;
        REG_WAKE_IGNORE_TIME:     ignore_time = data;
        REG_TICK_STEP:            tick_step = data[STEP_W-1:0];
        REG_SLEEP_HOLD_TIME:      sleep_time = data;
        REG_BRIGHTNESS_HOLD_TIME: bright_time = data;
        REG_BRIGHTNESS_AMOUNT:    cancel_amount = data;
        REG_DELTA_MULTIPLIER:     multiplier = data[MULT_W-1:0];
        default: ;
      endcase
    endfunction

    function int tick_down(int v, int step);
      return (v > step) ? v - step : 0;
    endfunction

    function int clip(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void note_tick(tick_t t);
      int          step;
      int          color;
      int          bright;
      int          delta;
      int          acc;
      bit          edge_on;
      bit          prev_poll;
      bit          both_on;
      logic [15:0] diff;
      outcome_t    o;
      step   = (tick_step == 0) ? 1 : tick_step;
      color  = 0;
      bright = 0;
      o.jump  = 1'b0;
      o.sleep = 1'b0;

      if (t.wake) begin
        poll_left   = 0;
        edge_left   = 0;
        held        = 0;
        accum       = 0;
        cancelled   = 1'b0;
        ignore_left = ignore_time;
      end

      o.act = t.sw_edge || t.enc_edge;
      if (t.sw_edge && ignore_left == 0) edge_left = hold_ticks;
      edge_on = edge_left > 0;

      prev_poll = poll_on;
      if (ignore_left == 0 && t.pressed) poll_left = hold_ticks;
      poll_on = poll_left > 0;
      if (prev_poll != poll_on) o.act = 1'b1;

      // The press fires once and re-arms only after both detections drop.
      both_on = edge_on && poll_on;
      if (!latched) begin
        if (both_on) begin
          o.jump  = 1'b1;
          latched = 1'b1;
        end
      end else if (!edge_on && !poll_on) begin
        latched = 1'b0;
      end

      poll_left   = tick_down(poll_left, step);
      edge_left   = tick_down(edge_left, step);
      ignore_left = tick_down(ignore_left, step);

      if (poll_on) begin
        held = held + step;
        if (held > int'(HELD_MAX)) held = int'(HELD_MAX);
        if (sleep_time > 0) begin
          if (held >= sleep_time) begin
            if (cancelled) held = sleep_time;
            else o.sleep = 1'b1;
          end
        end else if (held > bright_time) begin
          held = bright_time;
        end
      end else begin
        held      = 0;
        accum     = 0;
        cancelled = 1'b0;
      end

      if (t.position != last_pos) begin
        diff  = last_pos - t.position;
        delta = int'($signed(diff));
        delta = delta * multiplier;
        if (delta != 0) begin
          if (bright_time > 0 && held >= bright_time) begin
            bright = delta;
            acc    = clip(accum + delta, ACC_MIN, ACC_MAX);
            accum  = acc;
            if (((acc < 0) ? -acc : acc) >= cancel_amount) cancelled = 1'b1;
          end else begin
            color = delta;
          end
          o.act = 1'b1;
        end
        last_pos = t.position;
      end

      color    = clip(color, DELTA_MIN, DELTA_MAX);
      bright   = clip(bright, DELTA_MIN, DELTA_MAX);
      o.color  = color[DELTA_W-1:0];
      o.bright = bright[DELTA_W-1:0];
      outcomes.push_back(o);
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (outcomes.size() == 0) begin
        $error("result transfer with no tick pending");
        errors++;
        return;
      end
      want = outcomes.pop_front();
      if (got.jump !== want.jump) begin
        $error("jump_color: expected %0d, actual %0d", want.jump, got.jump);
        errors++;
      end
      if (got.color !== want.color) begin
        $error("color_delta: expected %0d, actual %0d", $signed(want.color), $signed(got.color));
        errors++;
      end
      if (got.bright !== want.bright) begin
        $error("brightness_delta: expected %0d, actual %0d", $signed(want.bright),
               $signed(got.bright));
        errors++;
      end
      if (got.sleep !== want.sleep) begin
        $error("sleep_request: expected %0d, actual %0d", want.sleep, got.sleep);
        errors++;
      end
      if (got.act !== want.act) begin
        $error("activity: expected %0d, actual %0d", want.act, got.act);
        errors++;
      end
    endfunction

    function int pending();
      return outcomes.size();
    endfunction
  endclass

endpackage

// ----- sim/tb_encoder_switch_input_qualifier.sv -----
`timescale 1ns / 1ps

module tb_encoder_switch_input_qualifier;
  import esiq_pkg::*;
  import esiq_check_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      tick_valid = 1'b0;
  logic                      tick_stall;
  logic                      switch_pressed = 1'b0;
  logic                      switch_edge_seen = 1'b0;
  logic                      encoder_edge_seen = 1'b0;
  logic signed [15:0]        encoder_position = '0;
  logic                      wake_clear = 1'b0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic                      jump_color;
  logic signed [DELTA_W-1:0] color_delta;
  logic signed [DELTA_W-1:0] brightness_delta;
  logic                      sleep_request;
  logic                      activity;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  qualifier_scoreboard sb = new();

  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 hold_requests = 0;
  int                 hold_served = 0;
  int                 hold_left = 0;
  int                 sent = 0;
  logic signed [15:0] enc_count = '0;

  encoder_switch_input_qualifier u_top (
    .clk              (clk),
    .rst              (rst),
    .tick_valid       (tick_valid),
    .tick_stall       (tick_stall),
    .switch_pressed   (switch_pressed),
    .switch_edge_seen (switch_edge_seen),
    .encoder_edge_seen(encoder_edge_seen),
    .encoder_position (encoder_position),
    .wake_clear       (wake_clear),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .jump_color       (jump_color),
    .color_delta      (color_delta),
    .brightness_delta (brightness_delta),
    .sleep_request    (sleep_request),
    .activity         (activity),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    outcome_t got;
    if (!rst && result_valid && !result_stall) begin
      got.jump   = jump_color;
      got.color  = color_delta;
      got.bright = brightness_delta;
      got.sleep  = sleep_request;
      got.act    = activity;
      sb.check_outcome(got);
    end
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic tick_t mk_tick(bit p, bit se, bit ee, logic signed [15:0] pos, bit w);
    tick_t t;
    t.pressed  = p;
    t.sw_edge  = se;
    t.enc_edge = ee;
    t.position = pos;
    t.wake     = w;
    return t;
  endfunction

  function automatic logic signed [15:0] next_position();
    int r;
    r = $urandom_range(99);
    if (r >= 90) enc_count = 16'($urandom_range(65535));
    else if (r >= 45) enc_count = enc_count + 16'($urandom_range(8)) - 16'sd4;
    return enc_count;
  endfunction

  function automatic reg_set_t random_regs();
    reg_set_t c;
    c.hold   = $urandom_range(20);
    c.ignore = $urandom_range(30);
    c.step   = ($urandom_range(99) < 70) ? $urandom_range(8, 1) : $urandom_range(255, 1);
    c.sleep  = $urandom_range(300);
    c.bright = $urandom_range(150);
    c.amount = $urandom_range(200, 1);
    c.mult   = $urandom_range(15, 1);
    return c;
  endfunction

  task automatic set_idling(input int s, input int r);
    send_idle_pct = s;
    recv_idle_pct <= r;
  endtask

  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid        <= 1'b1;
    switch_pressed    <= t.pressed;
    switch_edge_seen  <= t.sw_edge;
    encoder_edge_seen <= t.enc_edge;
    encoder_position  <= t.position;
    wake_clear        <= t.wake;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    sb.note_tick(t);
    sent++;
  endtask

  task automatic drain();
    tick_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, CFG_DATA_W'(data));
  endtask

  task automatic apply_config(input reg_set_t c);
    write_reg(REG_SWITCH_HOLD_TICKS, c.hold);
    write_reg(REG_WAKE_IGNORE_TIME, c.ignore);
    write_reg(REG_TICK_STEP, c.step);
    write_reg(REG_SLEEP_HOLD_TIME, c.sleep);
    write_reg(REG_BRIGHTNESS_HOLD_TIME, c.bright);
    write_reg(REG_BRIGHTNESS_AMOUNT, c.amount);
    write_reg(REG_DELTA_MULTIPLIER, c.mult);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly press and release episodes with random content, some wake pulses and noise.
  task automatic run_random(input int n);
    int target;
    int r;
    int len;
    int i;
    target = sent + n;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r < 75) begin
        len = $urandom_range(40, 1);
        for (i = 0; i < len; i++) begin
          send_tick(mk_tick($urandom_range(99) < 90, (i == 0) || ($urandom_range(99) < 10),
                            $urandom_range(99) < 30, next_position(), $urandom_range(199) == 0));
        end
        len = $urandom_range(20, 1);
        for (i = 0; i < len; i++) begin
          send_tick(mk_tick(1'b0, $urandom_range(99) < 5, $urandom_range(99) < 30,
                            next_position(), 1'b0));
        end
      end else if (r < 85) begin
        send_tick(mk_tick($urandom_range(1), $urandom_range(1), $urandom_range(1),
                          next_position(), 1'b1));
      end else begin
        len = $urandom_range(5, 1);
        for (i = 0; i < len; i++) begin
          send_tick(mk_tick($urandom_range(1), $urandom_range(1), $urandom_range(1),
                            16'($urandom_range(65535)), $urandom_range(1)));
        end
      end
    end
  endtask

  initial begin
    reg_set_t c;
    int       ph;
    int       i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_idling(7, 55);

    run_random(100);
    drain();

    // Zero tick step, sleep disabled, zero cancel amount and the largest multiplier.
    c = '{hold: 3, ignore: 4, step: 0, sleep: 0, bright: 2, amount: 0, mult: 15};
    apply_config(c);
    send_tick(mk_tick(1'b1, 1'b1, 1'b0, 16'sd0, 1'b1));
    send_tick(mk_tick(1'b1, 1'b1, 1'b1, 16'sd5, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 1'b0, 16'sd5, 1'b0));
    send_tick(mk_tick(1'b0, 1'b0, 1'b1, -16'sd3, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 1'b0, -16'sd3, 1'b0));
    for (i = 0; i < 4; i++) begin
      send_tick(mk_tick(1'b1, 1'b0, 1'b1, 16'sh7FFF, 1'b0));
      send_tick(mk_tick(1'b1, 1'b0, 1'b1, 16'sh8000, 1'b0));
    end
    for (i = 0; i < 5; i++) send_tick(mk_tick(1'b0, 1'b0, 1'b0, 16'sh8000, 1'b0));
    send_tick(mk_tick(1'b1, 1'b0, 1'b0, 16'sh8000, 1'b0));
    for (i = 0; i < 4; i++) send_tick(mk_tick(1'b0, 1'b0, 1'b0, 16'sh8000, 1'b0));
    send_tick(mk_tick(1'b0, 1'b1, 1'b0, 16'sh8000, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 1'b0, 16'sd100, 1'b0));
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        1: c = '{hold: 65535, ignore: 65535, step: 255, sleep: 65535, bright: 65535,
                 amount: 65535, mult: 15};
        2: c = '{hold: 0, ignore: 0, step: 0, sleep: 0, bright: 0, amount: 0, mult: 0};
        default: c = random_regs();
      endcase
      if (ph == 4) c.sleep = 0;
      if (ph < 2) set_idling(7, 55);
      else if (ph < 4) set_idling(55, 7);
      else set_idling(0, 0);
      apply_config(c);
      if (ph == 0 || ph == 4) hold_requests <= hold_requests + 1;
      run_random(190);
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_encoder_switch_input_qualifier: PASS");
    end else begin
      $display("tb_encoder_switch_input_qualifier: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_encoder_switch_input_qualifier: FAIL");
    $finish;
  end

endmodule

// ----- encoder_switch_input_qualifier.f -----
hw/rtl/esiq_pkg.sv
hw/rtl/encoder_switch_input_qualifier.sv
sim/esiq_check_pkg.sv
sim/tb_encoder_switch_input_qualifier.sv
